>>> src/sswr_pkg.sv
package sswr_pkg;

	localparam int PATTERN_ROWS   = 32;
	localparam int ROW_PITCH_LOG2 = 13;
	localparam int SCREEN_WIDTH   = 2048;

	localparam int CLIP_W    = 12;
	localparam int PAT_W     = $clog2(PATTERN_ROWS);
	localparam int WORD_W    = 32;
	localparam int WORD_LOG2 = 5;
	localparam int WORD_BYTES_LOG2 = 7;
	localparam int OFF_W     = 24;
	localparam int COL_W     = (SCREEN_WIDTH > WORD_W) ? $clog2(SCREEN_WIDTH / WORD_W) : 1;
	localparam int XW        = $clog2(SCREEN_WIDTH) + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W     = $clog2(FIFO_DEPTH);
	localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam int S_DATA_W  = 88;
	localparam int M_DATA_W  = 88;

	localparam logic [WORD_W-1:0] FULL_MASK = '1;

	typedef enum logic [1:0] {
		REG_CLIP_LEFT   = 2'd0,
		REG_CLIP_TOP    = 2'd1,
		REG_CLIP_RIGHT  = 2'd2,
		REG_CLIP_BOTTOM = 2'd3
	} reg_idx_t;

	typedef enum logic {
		MODE_SPAN = 1'b0,
		MODE_LOAD = 1'b1
	} mode_t;

	// one clipped span waiting for the word writer
	typedef struct packed {
		logic [OFF_W-1:0]  row_off;
		logic [COL_W-1:0]  col_first;
		logic [COL_W-1:0]  col_last;
		logic [WORD_W-1:0] first_mask;
		logic [WORD_W-1:0] last_mask;
		logic [WORD_W-1:0] pattern;
		logic              fin;
	} span_t;

endpackage

>>> src/sswr_front.sv
module sswr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_addr,
	input  logic [sswr_pkg::CLIP_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_mode,
	input  logic [sswr_pkg::S_DATA_W-1:0] in_data,
	input  logic                        in_fin,
	output logic                        push,
	output sswr_pkg::span_t             span
);
	import sswr_pkg::*;

	logic [CLIP_W-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic [WORD_W-1:0] pat_q [PATTERN_ROWS];

	logic signed [15:0] x_in, y_in;
	logic [14:0]        w_in;
	logic [4:0]         pidx_in;
	logic [WORD_W-1:0]  pword_in;

	logic signed [17:0] xv, xs, xe0, xe, right, clv;
	logic               row_ok, span_ok;
	logic [XW-1:0]      xs_u, xe_u, xe_m1;
	logic [PAT_W-1:0]   prow, lrow;
	logic [OFF_W-1:0]   yz;
	logic [WORD_LOG2-1:0] xe_lo;

	assign x_in     = in_data[15:0];
	assign y_in     = in_data[31:16];
	assign w_in     = in_data[46:32];
	assign pidx_in  = in_data[51:47];
	assign pword_in = in_data[83:52];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= CLIP_W'(SCREEN_WIDTH);
			clip_bottom_q <= CLIP_W'(SCREEN_WIDTH);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_CLIP_LEFT:   clip_left_q   <= cfg_wdata;
				REG_CLIP_TOP:    clip_top_q    <= cfg_wdata;
				REG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata;
				REG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign lrow = PAT_W'(32'(pidx_in) % PATTERN_ROWS);
	assign prow = PAT_W'(32'(unsigned'(y_in)) % PATTERN_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_ROWS; i++)
				pat_q[i] <= '0;
		end else if (in_valid && mode_t'(in_mode) == MODE_LOAD) begin
			pat_q[lrow] <= pword_in;
		end
	end

	always_comb begin
		xv    = 18'(x_in);
		clv   = $signed({6'b0, clip_left_q});
		xs    = (xv < clv) ? clv : xv;
		xe0   = xv + $signed({3'b0, w_in});
		right = (clip_right_q > CLIP_W'(SCREEN_WIDTH)) ? 18'(SCREEN_WIDTH)
		                                              : $signed({6'b0, clip_right_q});
		xe    = (xe0 < right) ? xe0 : right;
		row_ok = ($signed({y_in[15], y_in}) >= $signed({5'b0, clip_top_q}))
		      && ($signed({y_in[15], y_in}) <  $signed({5'b0, clip_bottom_q}));
		// span survives when something is left between the clipped edges
		span_ok = (xe0 > xs) && (right > xs);
		xs_u  = XW'(xs);
		xe_u  = XW'(xe);
		xe_m1 = xe_u - XW'(1);
		xe_lo = xe_u[WORD_LOG2-1:0];
		yz    = OFF_W'(unsigned'(y_in));

		span.row_off    = yz << ROW_PITCH_LOG2;
		span.col_first  = COL_W'(xs_u >> WORD_LOG2);
		span.col_last   = COL_W'(xe_m1 >> WORD_LOG2);
		span.first_mask = FULL_MASK >> xs_u[WORD_LOG2-1:0];
		span.last_mask  = (xe_lo == '0) ? FULL_MASK
		                                : FULL_MASK << (6'(WORD_W) - 6'(xe_lo));
		span.pattern    = pat_q[prow];
		span.fin        = in_fin;

		push = in_valid && mode_t'(in_mode) == MODE_SPAN && row_ok && span_ok;
	end

endmodule

>>> src/sswr_fifo.sv
module sswr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sswr_pkg::span_t wr_span,
	input  logic            pop,
	output sswr_pkg::span_t rd_span,
	output logic            full,
	output logic            empty
);
	import sswr_pkg::*;

	span_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full    = count_q == CNT_W'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign rd_span = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_span;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("span queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("span queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("span queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("span queue pointers disagree with count");

endmodule

>>> src/sswr_back.sv
module sswr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sswr_pkg::span_t               head,
	input  logic                          head_empty,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sswr_pkg::M_DATA_W-1:0] out_data,
	output logic                          out_last,
	output logic                          out_user
);
	import sswr_pkg::*;

	logic [COL_W-1:0] col_q, cur;
	logic             started_q, adv, is_last;
	logic [WORD_W-1:0] mask;
	logic [OFF_W-1:0]  offset;
	logic              valid_q, last_q, user_q;
	logic [M_DATA_W-1:0] data_q;

	always_comb begin
		cur     = started_q ? col_q : head.col_first;
		is_last = cur == head.col_last;
		mask    = FULL_MASK;
		if (cur == head.col_first)
			mask = mask & head.first_mask;
		if (is_last)
			mask = mask & head.last_mask;
		offset  = head.row_off + (OFF_W'(cur) << WORD_BYTES_LOG2);
		// output register free or being drained this cycle
		adv     = !head_empty && (!valid_q || out_ready);
		pop     = adv && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			started_q <= 1'b0;
			col_q     <= '0;
		end else begin
			if (adv) begin
				valid_q   <= 1'b1;
				started_q <= !is_last;
				col_q     <= cur + COL_W'(1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= {head.pattern, mask, offset};
			last_q <= is_last;
			user_q <= is_last && head.fin;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;
	assign out_user  = user_q;

	a_batch_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && user_q |-> last_q)
		else $error("batch end outside last word");
	a_pop_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !started_q && last_q)
		else $error("span popped before its last word");
	a_started_busy: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> !head_empty)
		else $error("mid-span with empty queue");

endmodule

>>> src/stipple_span_word_writer.sv
// Stippled span word writer.
// s_* channel: one beat per item. s_tuser is the mode (0 draw span, 1 load a
// stipple row), s_tlast marks the final span of a batch. Spans are clipped to
// the rectangle in the four clip registers (cfg_we/cfg_addr/cfg_wdata; write
// only while idle) and to the screen's right edge.
// m_* channel: one beat per 32-pixel word touched by the clipped span, left to
// right; m_tlast on the span's last word, m_tuser on that word when the span
// carried s_tlast.
// The accepted span is written into the span queue; its first word is then
// registered into the output register. Throughput: one word per cycle out of
// the back end while m_tready does not stall. Loads, spans clipped away and
// rows outside the rectangle are consumed with their input beat and give no
// beat. A 4-entry span queue sits between the clipping front and the word
// writer, so the input keeps flowing until it fills; s_tready drops only while
// the queue is full. Reset: clip rectangle covers the full screen, all stipple
// rows read zero, queue and output register are empty. A stall on m_tready
// holds the current word and backs up into the queue.
module stipple_span_word_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [sswr_pkg::CLIP_W-1:0]   cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// x_start[15:0], y_row[31:16], span_width[46:32], pattern_index[51:47],
	// pattern_word[83:52], zero pad
	input  logic [sswr_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                          s_tlast,  // final_span
	input  logic                          s_tuser,  // mode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// byte_offset[23:0], write_mask[55:24], pattern_bits[87:56]
	output logic [sswr_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast,  // run_last
	output logic                          m_tuser   // batch_end
);
	import sswr_pkg::*;

	span_t  new_span, head_span;
	logic   q_push, q_pop, q_full, q_empty;
	logic   in_beat;

	assign s_tready = !q_full;
	assign in_beat  = s_tvalid && s_tready;

	sswr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_beat),
		.in_mode  (s_tuser),
		.in_data  (s_tdata),
		.in_fin   (s_tlast),
		.push     (q_push),
		.span     (new_span)
	);

	sswr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_span(new_span),
		.pop    (q_pop),
		.rd_span(head_span),
		.full   (q_full),
		.empty  (q_empty)
	);

	sswr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_span),
		.head_empty(q_empty),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.out_user  (m_tuser)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sswr_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int DRAIN_CYCLES = 16;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		mode_t              mode;
		logic signed [15:0] x_start;
		logic signed [15:0] y_row;
		logic [14:0]        span_width;
		logic [4:0]         pattern_index;
		logic [31:0]        pattern_word;
		logic               final_span;
	} span_cmd_t;

	typedef struct packed {
		logic [OFF_W-1:0]  byte_offset;
		logic [WORD_W-1:0] write_mask;
		logic [WORD_W-1:0] pattern_bits;
		logic              run_last;
		logic              batch_end;
	} word_wr_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [1:0]          cfg_addr  = REG_CLIP_LEFT;
	logic [CLIP_W-1:0]   cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic                s_tlast   = 1'b0;
	logic                s_tuser   = MODE_SPAN;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;
	logic                m_tuser;

	stipple_span_word_writer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #CLK_HALF clk = ~clk;

	// shadow of the block's state
	logic [WORD_W-1:0] stipple_rows [PATTERN_ROWS];
	int clip_l = 0;
	int clip_t = 0;
	int clip_r = SCREEN_WIDTH;
	int clip_b = SCREEN_WIDTH;

	word_wr_t pending_words [$];

	int errors        = 0;
	int items_sent    = 0;
	int loads_sent    = 0;
	int words_seen    = 0;
	int clip_settings = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	task automatic note_error(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// expected word writes for one accepted beat
	function automatic void predict_words(input span_cmd_t it);
		int x, y, w, right, xe, cfirst, clast;
		logic [31:0] yu;
		logic [OFF_W-1:0] row_base;
		logic [WORD_W-1:0] mask;
		word_wr_t wd;
		if (it.mode == MODE_LOAD) begin
			stipple_rows[it.pattern_index % PATTERN_ROWS] = it.pattern_word;
			return;
		end
		x = it.x_start;
		y = it.y_row;
		w = it.span_width;
		if (y < clip_t || y >= clip_b || w <= 0)
			return;
		right = (clip_r > SCREEN_WIDTH) ? SCREEN_WIDTH : clip_r;
		if (x < clip_l) begin
			w -= clip_l - x;
			if (w <= 0)
				return;
			x = clip_l;
		end
		if (x >= right)
			return;
		if (x + w > right)
			w = right - x;
		xe = x + w;
		yu = 32'(y);
		row_base = OFF_W'(yu << ROW_PITCH_LOG2);
		cfirst = x >> WORD_LOG2;
		clast = (xe - 1) >> WORD_LOG2;
		for (int c = cfirst; c <= clast; c++) begin
			mask = FULL_MASK;
			if (c == cfirst)
				mask &= FULL_MASK >> (x & 31);
			if (c == clast && (xe & 31) != 0)
				mask &= FULL_MASK << (32 - (xe & 31));
			wd.byte_offset  = OFF_W'(row_base + (c << WORD_BYTES_LOG2));
			wd.write_mask   = mask;
			wd.pattern_bits = stipple_rows[yu % PATTERN_ROWS];
			wd.run_last     = (c == clast);
			wd.batch_end    = (c == clast) ? it.final_span : 1'b0;
			pending_words.push_back(wd);
		end
	endfunction

	function automatic span_cmd_t span_cmd(input int x, input int y, input int w, input bit fin);
		span_cmd_t it;
		it.mode          = MODE_SPAN;
		it.x_start       = 16'(x);
		it.y_row         = 16'(y);
		it.span_width    = 15'(w);
		it.pattern_index = 5'($urandom);
		it.pattern_word  = $urandom;
		it.final_span    = fin;
		return it;
	endfunction

	function automatic span_cmd_t load_cmd(input int idx, input logic [31:0] bits);
		span_cmd_t it;
		it = span_cmd($urandom, $urandom, $urandom, $urandom_range(1, 0));
		it.mode          = MODE_LOAD;
		it.pattern_index = 5'(idx);
		it.pattern_word  = bits;
		return it;
	endfunction

	// caller must not let time pass between back-to-back sends
	task automatic send_item(input span_cmd_t it);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.mode;
		s_tlast  <= it.final_span;
		s_tdata  <= {4'b0, it.pattern_word, it.pattern_index, it.span_width,
			it.y_row, it.x_start};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (it.mode == MODE_LOAD)
			loads_sent++;
		predict_words(it);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		// loads and clipped spans leave no beat behind, give them time to clear
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_clip(input int l, input int t, input int r, input int b);
		int vals [4];
		vals = '{l, t, r, b};
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= reg_idx_t'(i);
			cfg_wdata <= CLIP_W'(vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		clip_l = l;
		clip_t = t;
		clip_r = r;
		clip_b = b;
		clip_settings++;
	endtask

	task automatic program_random_clip();
		int l, t, r, b;
		case ($urandom_range(3, 0))
			0: begin
				l = 0; t = 0; r = SCREEN_WIDTH; b = SCREEN_WIDTH;
			end
			1: begin
				// tiny rectangle hugging the bottom-right corner
				l = SCREEN_WIDTH - $urandom_range(40, 1);
				t = SCREEN_WIDTH - $urandom_range(8, 1);
				r = SCREEN_WIDTH;
				b = SCREEN_WIDTH;
			end
			default: begin
				l = $urandom_range(1024, 0);
				r = $urandom_range(SCREEN_WIDTH, l + 1);
				t = $urandom_range(1024, 0);
				b = $urandom_range(SCREEN_WIDTH, t + 1);
			end
		endcase
		program_clip(l, t, r, b);
	endtask

	function automatic span_cmd_t random_cmd();
		span_cmd_t it;
		int pick, x, y, w;
		pick = $urandom_range(99, 0);
		if (pick < 12)
			return load_cmd($urandom, $urandom);
		if (pick < 22) begin
			it = span_cmd($urandom, $urandom, $urandom, $urandom_range(1, 0));
			it.mode = mode_t'($urandom_range(1, 0));
			return it;
		end
		if (clip_t < clip_b)
			y = $urandom_range(clip_b - 1, clip_t);
		else
			y = $urandom_range(SCREEN_WIDTH - 1, 0);
		x = clip_l - 64 + $urandom_range(((clip_r > clip_l) ? clip_r - clip_l : 0) + 128, 0);
		pick = $urandom_range(99, 0);
		if (pick < 85)
			w = $urandom_range(320, 1);
		else if (pick < 95)
			w = $urandom_range(2200, 0);
		else
			w = $urandom_range(32767, 0);
		return span_cmd(x, y, w, $urandom_range(1, 0));
	endfunction

	// -------------------------------------------------------------------------
	// output side

	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	word_wr_t got_word, want_word;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_word.byte_offset  = m_tdata[OFF_W-1:0];
			got_word.write_mask   = m_tdata[OFF_W +: WORD_W];
			got_word.pattern_bits = m_tdata[OFF_W + WORD_W +: WORD_W];
			got_word.run_last     = m_tlast;
			got_word.batch_end    = m_tuser;
			words_seen++;
			if (pending_words.size() == 0) begin
				note_error($sformatf("unexpected beat off=%h mask=%h pat=%h last=%b end=%b",
					got_word.byte_offset, got_word.write_mask, got_word.pattern_bits,
					got_word.run_last, got_word.batch_end));
			end else begin
				want_word = pending_words.pop_front();
				if (got_word != want_word)
					note_error($sformatf({"beat %0d: off %h/%h mask %h/%h pat %h/%h",
						" last %b/%b end %b/%b (expected/actual)"}, words_seen,
						want_word.byte_offset, got_word.byte_offset,
						want_word.write_mask, got_word.write_mask,
						want_word.pattern_bits, got_word.pattern_bits,
						want_word.run_last, got_word.run_last,
						want_word.batch_end, got_word.batch_end));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TIMEOUT: no beat for %0d cycles, %0d words outstanding",
				quiet_cycles, pending_words.size());
			$display("tb_top failed");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// tests

	task automatic test_full_screen_span();
		send_item(span_cmd(0, 0, SCREEN_WIDTH, 1'b1));
		send_item(span_cmd(5, 3, 0, 1'b1));
		send_item(span_cmd(-40, 7, 50, 1'b0));
	endtask

	task automatic test_stipple_rows();
		send_item(load_cmd(0, 32'hffff_ffff));
		send_item(load_cmd(PATTERN_ROWS - 1, 32'h8000_0001));
		send_item(load_cmd(5, $urandom));
		send_item(span_cmd(31, 31, 2, 1'b1));
		send_item(span_cmd(33, 5, 30, 1'b0));
		send_item(span_cmd(0, 32, 32, 1'b1));
	endtask

	task automatic test_field_extremes();
		send_item(span_cmd(32767, 10, 32767, 1'b1));
		send_item(span_cmd(-32768, 10, 32767, 1'b0));
		send_item(span_cmd(-30000, 20, 32767, 1'b1));
		send_item(span_cmd(0, -32768, 100, 1'b1));
		send_item(span_cmd(0, 32767, 100, 1'b1));
		send_item(span_cmd(SCREEN_WIDTH - 1, SCREEN_WIDTH - 1, 1, 1'b1));
	endtask

	task automatic test_clip_rectangle();
		program_clip(100, 50, 700, 400);
		send_item(span_cmd(90, 49, 50, 1'b1));
		send_item(span_cmd(90, 400, 50, 1'b1));
		send_item(span_cmd(90, 399, 50, 1'b1));
		send_item(span_cmd(650, 50, 200, 1'b0));
		// ends exactly on the left edge, nothing left
		send_item(span_cmd(0, 60, 100, 1'b1));
		send_item(span_cmd(0, 70, SCREEN_WIDTH, 1'b1));
	endtask

	task automatic test_inverted_clip();
		program_clip(500, 0, 500, SCREEN_WIDTH);
		send_item(span_cmd(400, 10, 300, 1'b1));
		program_clip(900, 300, 100, 200);
		send_item(span_cmd(0, 250, SCREEN_WIDTH, 1'b1));
	endtask

	task automatic test_offset_wrap();
		// right edge past the screen, rows beyond 2047 wrap the offset
		program_clip(0, 0, (1 << CLIP_W) - 1, (1 << CLIP_W) - 1);
		send_item(span_cmd(2000, 4094, 200, 1'b1));
		send_item(span_cmd(-5, 2048, 40, 1'b0));
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
		program_random_clip();
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < n / 2; i++)
			send_item(random_cmd());
		program_random_clip();
		for (int i = n / 2; i < n; i++)
			send_item(random_cmd());
	endtask

	task automatic test_backpressure();
		program_clip(0, 0, SCREEN_WIDTH, SCREEN_WIDTH);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs++;
		for (int i = 0; i < 16; i++)
			send_item(span_cmd($urandom_range(1500, 0), $urandom_range(2047, 0),
				$urandom_range(400, 64), $urandom_range(1, 0)));
	endtask

	initial begin
		for (int i = 0; i < PATTERN_ROWS; i++)
			stipple_rows[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_screen_span();
		test_stipple_rows();
		test_field_extremes();
		test_clip_rectangle();
		test_inverted_clip();
		test_offset_wrap();
		test_random_traffic(0, 0, 55);
		test_random_traffic(75, 0, 55);
		test_random_traffic(0, 75, 55);
		test_random_traffic(29, 29, 55);
		test_backpressure();

		wait_drained();
		$display("Covered: %0d items (%0d stipple loads), %0d word writes, %0d clip settings",
			items_sent, loads_sent, words_seen, clip_settings);
		$display("Idle mixes: none, sender 75%%, receiver 75%%, both 29%%, plus a long stall");
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

>>> files.f
src/sswr_pkg.sv
src/sswr_front.sv
src/sswr_fifo.sv
src/sswr_back.sv
src/stipple_span_word_writer.sv
tb/tb_top.sv
